// ===== hdl/lorenz_rk4_step_macros.svh =====
// Assertion macros used by the checker of the Lorenz RK4 step block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef LORENZ_RK4_STEP_MACROS_SVH
`define LORENZ_RK4_STEP_MACROS_SVH

// check while out of reset
`define LRK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check at every edge, reset included
`define LRK_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/lrk_pkg.sv =====
// Types, constants and arithmetic helpers for the Lorenz RK4 step block.
// No dependencies; used by every module of the block.
package lrk_pkg;

  localparam int FRAC_BITS    = 24;
  localparam int GAIN_W       = 31;
  localparam int DT_W         = 25;
  localparam int ACC_W        = 35;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;
  localparam int SLOPE_STAGES = 4;
  localparam int ADV_STAGES   = 2;
  localparam int FINAL_STAGES = 6;
  localparam int PIPE_STAGES  = 4 * SLOPE_STAGES + 3 * ADV_STAGES + FINAL_STAGES;

  localparam logic signed [65:0] Q_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] Q_MIN_W = -66'sd2147483648;
  localparam logic [20:0]        DIV3_MUL = 21'd699051;

  localparam logic [GAIN_W-1:0] SIGMA_RST = 31'd167772160;
  localparam logic [GAIN_W-1:0] RHO_RST   = 31'd469762048;
  localparam logic [GAIN_W-1:0] BETA_RST  = 31'd44739243;
  localparam logic [DT_W-1:0]   DT_RST    = 25'd167772;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA = 8'd0,
    REG_RHO   = 8'd1,
    REG_BETA  = 8'd2,
    REG_DT    = 8'd3
  } lrk_reg_e;

  typedef logic signed [31:0]      q_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef q_t [2:0]                vec_t;
  typedef acc_t [2:0]              acc_vec_t;

  typedef struct packed {
    q_t   x_in;
    q_t   y_in;
    q_t   z_in;
    logic last_in;
  } lrk_in_t;

  typedef struct packed {
    q_t   x_out;
    q_t   y_out;
    q_t   z_out;
    logic saturated;
    logic last_out;
  } lrk_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] sigma_gain;
    logic [GAIN_W-1:0] rho_gain;
    logic [GAIN_W-1:0] beta_gain;
    logic [DT_W-1:0]   time_step;
  } lrk_cfg_t;

  typedef struct packed {
    vec_t     p;
    acc_vec_t acc;
    logic     sat;
    logic     last;
  } lrk_ctx_t;

  typedef struct packed {
    q_t   val;
    logic sat;
  } lrk_sat_t;

  function automatic lrk_sat_t sat_q(input logic signed [65:0] v);
    lrk_sat_t r;
    r.sat = 1'b1;
    if (v > Q_MAX_W) begin
      r.val = 32'h7FFF_FFFF;
    end else if (v < Q_MIN_W) begin
      r.val = 32'h8000_0000;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                 input logic [4:0] s);
    return (v + (66'sd1 <<< (s - 5'd1))) >>> s;
  endfunction

  function automatic logic [18:0] div3(input logic [19:0] x);
    logic [40:0] m;
    m = x * DIV3_MUL;
    return m[39:21];
  endfunction

endpackage

// ===== hdl/lrk_stage_ctl.sv =====
// Valid bits and per-stage advance enables of one pipeline section.
// Depends on lrk_pkg for its default depth.
module lrk_stage_ctl #(
  parameter int STAGES = lrk_pkg::SLOPE_STAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [STAGES-1:0] adv_o
);

  logic [STAGES-1:0] vld_q;

  always_comb begin
    adv_o[STAGES-1] = !vld_q[STAGES-1] || ready_i;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv_o[i] = !vld_q[i] || adv_o[i+1];
    end
  end

  assign ready_o = adv_o[0];
  assign valid_o = vld_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv_o[0]) vld_q[0] <= valid_i;
      for (int i = 1; i < STAGES; i++) begin
        if (adv_o[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

endmodule

// ===== hdl/lrk_slope.sv =====
// Lorenz slope evaluation at one point, four register stages.
// Depends on lrk_pkg and lrk_stage_ctl.
module lrk_slope (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrk_pkg::lrk_cfg_t cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  lrk_pkg::lrk_ctx_t ctx_i,
  input  lrk_pkg::vec_t     pt_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lrk_pkg::lrk_ctx_t ctx_o,
  output lrk_pkg::vec_t     k_o
);

  logic [lrk_pkg::SLOPE_STAGES-1:0] adv;

  lrk_pkg::lrk_ctx_t   c1_q, c2_q, c3_q, c4_q, c3_d, c4_d;
  lrk_pkg::q_t         x1_q, y1_q, z1_q, y2_q, y3_q;
  logic signed [32:0]  d0_d, d1_d, d0_q, d1_q;
  logic signed [64:0]  p_d [4];
  logic signed [64:0]  p_q [4];
  lrk_pkg::lrk_sat_t   r3 [4];
  lrk_pkg::q_t         m_q [4];
  lrk_pkg::lrk_sat_t   s4a, s4b;
  lrk_pkg::vec_t       k_q;

  lrk_stage_ctl #(
    .STAGES(lrk_pkg::SLOPE_STAGES)
  ) u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .adv_o  (adv)
  );

  always_comb begin
    d0_d = 33'($signed(pt_i[1])) - 33'($signed(pt_i[0]));
    d1_d = $signed({2'b00, cfg_i.rho_gain}) - 33'($signed(pt_i[2]));
    p_d[0] = $signed({1'b0, cfg_i.sigma_gain}) * d0_q;
    p_d[1] = x1_q * d1_q;
    p_d[2] = x1_q * y1_q;
    p_d[3] = $signed({1'b0, cfg_i.beta_gain}) * z1_q;
    for (int j = 0; j < 4; j++) begin
      r3[j] = lrk_pkg::sat_q(lrk_pkg::rnd_shr(66'(p_q[j]), 5'(lrk_pkg::FRAC_BITS)));
    end
    c3_d = c2_q;
    c3_d.sat = c2_q.sat | r3[0].sat | r3[1].sat | r3[2].sat | r3[3].sat;
    s4a = lrk_pkg::sat_q(66'(m_q[1]) - 66'(y3_q));
    s4b = lrk_pkg::sat_q(66'(m_q[2]) - 66'(m_q[3]));
    c4_d = c3_q;
    c4_d.sat = c3_q.sat | s4a.sat | s4b.sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      c1_q <= ctx_i;
      x1_q <= pt_i[0];
      y1_q <= pt_i[1];
      z1_q <= pt_i[2];
      d0_q <= d0_d;
      d1_q <= d1_d;
    end
    if (adv[1]) begin
      c2_q <= c1_q;
      y2_q <= y1_q;
      for (int j = 0; j < 4; j++) p_q[j] <= p_d[j];
    end
    if (adv[2]) begin
      c3_q <= c3_d;
      y3_q <= y2_q;
      for (int j = 0; j < 4; j++) m_q[j] <= r3[j].val;
    end
    if (adv[3]) begin
      c4_q   <= c4_d;
      k_q[0] <= m_q[0];
      k_q[1] <= s4a.val;
      k_q[2] <= s4b.val;
    end
  end

  assign ctx_o = c4_q;
  assign k_o   = k_q;

endmodule

// ===== hdl/lrk_advance.sv =====
// Stage point update p + dt*k (half or full step) and weighted slope sum.
// Depends on lrk_pkg and lrk_stage_ctl.
module lrk_advance (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrk_pkg::lrk_cfg_t cfg_i,
  input  logic              half_i,
  input  logic              dbl_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  lrk_pkg::lrk_ctx_t ctx_i,
  input  lrk_pkg::vec_t     k_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lrk_pkg::lrk_ctx_t ctx_o,
  output lrk_pkg::vec_t     pt_o
);

  logic [lrk_pkg::ADV_STAGES-1:0] adv;

  lrk_pkg::lrk_ctx_t  c1_d, c1_q, c2_d, c2_q;
  logic signed [57:0] pr_d [3];
  logic signed [57:0] pr_q [3];
  lrk_pkg::lrk_sat_t  s2 [3];
  lrk_pkg::vec_t      pt_q;
  logic [4:0]         shamt;

  lrk_stage_ctl #(
    .STAGES(lrk_pkg::ADV_STAGES)
  ) u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .adv_o  (adv)
  );

  always_comb begin
    c1_d = ctx_i;
    for (int j = 0; j < 3; j++) begin
      pr_d[j] = $signed({1'b0, cfg_i.time_step}) * $signed(k_i[j]);
      c1_d.acc[j] = $signed(ctx_i.acc[j]) +
                    (dbl_i ? (lrk_pkg::ACC_W'($signed(k_i[j])) <<< 1)
                           : lrk_pkg::ACC_W'($signed(k_i[j])));
    end
    shamt = half_i ? 5'(lrk_pkg::FRAC_BITS + 1) : 5'(lrk_pkg::FRAC_BITS);
    c2_d = c1_q;
    for (int j = 0; j < 3; j++) begin
      s2[j] = lrk_pkg::sat_q(66'($signed(c1_q.p[j])) +
                             lrk_pkg::rnd_shr(66'(pr_q[j]), shamt));
    end
    c2_d.sat = c1_q.sat | s2[0].sat | s2[1].sat | s2[2].sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      c1_q <= c1_d;
      for (int j = 0; j < 3; j++) pr_q[j] <= pr_d[j];
    end
    if (adv[1]) begin
      c2_q <= c2_d;
      for (int j = 0; j < 3; j++) pt_q[j] <= s2[j].val;
    end
  end

  assign ctx_o = c2_q;
  assign pt_o  = pt_q;

endmodule

// ===== hdl/lrk_final.sv =====
// Final combination p + dt*(k1+2k2+2k3+k4)/6 with floor division and clamp.
// Depends on lrk_pkg and lrk_stage_ctl.
module lrk_final (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrk_pkg::lrk_cfg_t cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  lrk_pkg::lrk_ctx_t ctx_i,
  input  lrk_pkg::vec_t     k_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lrk_pkg::lrk_out_t data_o
);

  localparam logic signed [65:0] RND_OFS = 66'sd50331648;
  localparam logic signed [65:0] DIV_OFS = 66'sd25769803776;
  localparam logic signed [65:0] QUO_OFS = 66'sd8589934592;

  logic [lrk_pkg::FINAL_STAGES-1:0] adv;

  lrk_pkg::lrk_ctx_t  c1_q, c2_q, c3_q, c4_q, c5_q;
  lrk_pkg::acc_t      s_d [3];
  lrk_pkg::acc_t      s_q [3];
  logic signed [60:0] pr_d [3];
  logic signed [60:0] pr_q [3];
  logic signed [65:0] u_d [3];
  logic [35:0]        v_d [3];
  logic [35:0]        v_q [3];
  logic [18:0]        a_d [3];
  logic [17:0]        r_d [3];
  logic [16:0]        a_q [3];
  logic [1:0]         r1_q [3];
  logic [17:0]        vl_q [3];
  logic [18:0]        lo_d [3];
  logic [34:0]        quo_q [3];
  lrk_pkg::lrk_sat_t  f_d [3];
  lrk_pkg::lrk_out_t  out_d, out_q;

  lrk_stage_ctl #(
    .STAGES(lrk_pkg::FINAL_STAGES)
  ) u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_i),
    .ready_o(ready_o),
    .valid_o(valid_o),
    .ready_i(ready_i),
    .adv_o  (adv)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s_d[j]  = $signed(ctx_i.acc[j]) + lrk_pkg::ACC_W'($signed(k_i[j]));
      pr_d[j] = $signed({1'b0, cfg_i.time_step}) * s_q[j];
      u_d[j]  = (66'(pr_q[j]) + RND_OFS) >>> (lrk_pkg::FRAC_BITS + 1);
      v_d[j]  = 36'(u_d[j] + DIV_OFS);
      a_d[j]  = lrk_pkg::div3({2'b00, v_q[j][35:18]});
      r_d[j]  = v_q[j][35:18] - 18'(a_d[j] * 19'd3);
      lo_d[j] = lrk_pkg::div3({r1_q[j], vl_q[j]});
      f_d[j]  = lrk_pkg::sat_q(66'($signed(c5_q.p[j])) +
                               $signed({31'd0, quo_q[j]}) - QUO_OFS);
    end
    out_d.x_out     = f_d[0].val;
    out_d.y_out     = f_d[1].val;
    out_d.z_out     = f_d[2].val;
    out_d.saturated = c5_q.sat | f_d[0].sat | f_d[1].sat | f_d[2].sat;
    out_d.last_out  = c5_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      c1_q <= ctx_i;
      for (int j = 0; j < 3; j++) s_q[j] <= s_d[j];
    end
    if (adv[1]) begin
      c2_q <= c1_q;
      for (int j = 0; j < 3; j++) pr_q[j] <= pr_d[j];
    end
    if (adv[2]) begin
      c3_q <= c2_q;
      for (int j = 0; j < 3; j++) v_q[j] <= v_d[j];
    end
    if (adv[3]) begin
      c4_q <= c3_q;
      for (int j = 0; j < 3; j++) begin
        a_q[j]  <= a_d[j][16:0];
        r1_q[j] <= r_d[j][1:0];
        vl_q[j] <= v_q[j][17:0];
      end
    end
    if (adv[4]) begin
      c5_q <= c4_q;
      for (int j = 0; j < 3; j++) quo_q[j] <= {a_q[j], lo_d[j][17:0]};
    end
    if (adv[5]) begin
      out_q <= out_d;
    end
  end

  assign data_o = out_q;

endmodule

// ===== hdl/lorenz_rk4_step.sv =====
// Top level of the Lorenz RK4 step block: configuration registers and the
// slope / advance / final pipeline. Depends on lrk_pkg, lrk_slope,
// lrk_advance, lrk_final.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one particle (x, y, z, last)
//   per request; output channel out_valid_o/out_ready_i returns the particle
//   after one RK4 step, with a saturation flag and the copied last marker.
//   Configuration channel cfg_valid_i/cfg_ready_o writes sigma, rho, beta and
//   dt by index (0..3); other indexes are dropped. cfg_ready_o is always high.
//   Write configuration only while no request is in flight.
// Timing:
//   28 register stages: four slope evaluations of 4 stages, three point
//   updates of 2 stages, a 6-stage final combination. One request per cycle is
//   taken unless a stalled receiver has filled the pipeline.
//   Each stage advances when it is empty or its successor advances, so a
//   stalled receiver fills the pipeline bubble by bubble and loses nothing.
// Reset:
//   Clears all valid bits and loads the default parameters.
module lorenz_rk4_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lrk_pkg::lrk_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lrk_pkg::lrk_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lrk_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lrk_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  lrk_pkg::lrk_cfg_t cfg_q;
  lrk_pkg::lrk_ctx_t ctx0;
  lrk_pkg::vec_t     pt0;

  lrk_pkg::lrk_ctx_t sl_ctx [4];
  lrk_pkg::vec_t     sl_k   [4];
  logic              sl_vld [4];
  logic              sl_rdy [4];
  lrk_pkg::lrk_ctx_t ad_ctx [3];
  lrk_pkg::vec_t     ad_pt  [3];
  logic              ad_vld [3];
  logic              ad_rdy [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sigma_gain <= lrk_pkg::SIGMA_RST;
      cfg_q.rho_gain   <= lrk_pkg::RHO_RST;
      cfg_q.beta_gain  <= lrk_pkg::BETA_RST;
      cfg_q.time_step  <= lrk_pkg::DT_RST;
    end else if (cfg_valid_i) begin
      case (lrk_pkg::lrk_reg_e'(cfg_index_i))
        lrk_pkg::REG_SIGMA: cfg_q.sigma_gain <= cfg_data_i[lrk_pkg::GAIN_W-1:0];
        lrk_pkg::REG_RHO:   cfg_q.rho_gain   <= cfg_data_i[lrk_pkg::GAIN_W-1:0];
        lrk_pkg::REG_BETA:  cfg_q.beta_gain  <= cfg_data_i[lrk_pkg::GAIN_W-1:0];
        lrk_pkg::REG_DT:    cfg_q.time_step  <= cfg_data_i[lrk_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pt0[0]    = in_data_i.x_in;
    pt0[1]    = in_data_i.y_in;
    pt0[2]    = in_data_i.z_in;
    ctx0.p    = pt0;
    ctx0.acc  = '0;
    ctx0.sat  = 1'b0;
    ctx0.last = in_data_i.last_in;
  end

  for (genvar g = 0; g < 4; g++) begin : g_slope
    if (g == 0) begin : g_head
      lrk_slope u_slope (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cfg_i  (cfg_q),
        .valid_i(in_valid_i),
        .ready_o(in_ready_o),
        .ctx_i  (ctx0),
        .pt_i   (pt0),
        .valid_o(sl_vld[g]),
        .ready_i(sl_rdy[g]),
        .ctx_o  (sl_ctx[g]),
        .k_o    (sl_k[g])
      );
    end else begin : g_body
      lrk_slope u_slope (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cfg_i  (cfg_q),
        .valid_i(ad_vld[g-1]),
        .ready_o(ad_rdy[g-1]),
        .ctx_i  (ad_ctx[g-1]),
        .pt_i   (ad_pt[g-1]),
        .valid_o(sl_vld[g]),
        .ready_i(sl_rdy[g]),
        .ctx_o  (sl_ctx[g]),
        .k_o    (sl_k[g])
      );
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_adv
    lrk_advance u_adv (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg_q),
      .half_i (g != 2),
      .dbl_i  (g != 0),
      .valid_i(sl_vld[g]),
      .ready_o(sl_rdy[g]),
      .ctx_i  (sl_ctx[g]),
      .k_i    (sl_k[g]),
      .valid_o(ad_vld[g]),
      .ready_i(ad_rdy[g]),
      .ctx_o  (ad_ctx[g]),
      .pt_o   (ad_pt[g])
    );
  end

  lrk_final u_final (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .valid_i(sl_vld[3]),
    .ready_o(sl_rdy[3]),
    .ctx_i  (sl_ctx[3]),
    .k_i    (sl_k[3]),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o)
  );

endmodule

// ===== hdl/lrk_checker.sv =====
// Port-level checks of the Lorenz RK4 step block, bound to the top level.
// Depends on lrk_pkg and lorenz_rk4_step_macros.svh.
`include "lorenz_rk4_step_macros.svh"

module lrk_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input lrk_pkg::lrk_out_t out_data_o
);

  logic [5:0] cnt_q, cnt_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q + 6'(in_acc) - 6'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `LRK_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")
  `LRK_ASSERT(a_no_invent, out_valid_o |-> cnt_q != 6'd0, "result without a pending request")
  `LRK_ASSERT_ALWAYS(a_depth, cnt_q <= 6'(lrk_pkg::PIPE_STAGES), "more requests in flight than stages")
  `LRK_ASSERT(a_full_stall, cnt_q == 6'(lrk_pkg::PIPE_STAGES) && !out_ready_i |-> !in_ready_o, "request taken while pipeline full")

endmodule

bind lorenz_rk4_step lrk_checker u_lrk_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
